// ===== sv/sha256_pkg.sv =====
package sha256_pkg;

   localparam int WordWidth = 32;
   localparam int LenWidth = 61;
   localparam int RoundCount = 64;

   typedef enum logic [1:0] {
      FUNC_ABSORB  = 2'd0,
      FUNC_LOAD    = 2'd1,
      FUNC_RESTORE = 2'd2,
      FUNC_UNUSED  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_INIT,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   localparam logic [31:0] InitH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Control from the sequencer to the round unit.
   typedef struct packed {
      logic       init;    // copy chaining words into the working words
      logic       round;   // run one compression round
      logic [5:0] rnd;     // round number
   } rnd_ctl_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

// ===== sv/sha256_hash_engine.sv =====
// Flow: an absorb word that finishes a block starts a compression through the
// INIT, ROUND (64 rounds) and FOLD states. A final word brings padding, one or two
// compressions, then eight digest items. There is a single round unit, and new
// requests are taken only in the idle state, not while a block is padded,
// compressed or its digest is emitted.
// Synchronous active-high reset restores the initial chaining words and clears
// the byte count, block position and the length offset register.
module sha256_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: data_word[31:0], byte_count[34:32], state_index[37:35].
   input  logic [39:0] req_tdata,
   // Fields from bit 0: func[1:0].
   input  logic [1:0]  req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: digest_word[31:0], digest_index[34:32].
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   sha256_pkg::state_type   state_ff, state_in;
   sha256_pkg::rnd_ctl_type ctl;
   logic [31:0] chain_ff [8];
   logic [31:0] work [8];
   logic [31:0] w_word;
   logic [60:0] offset_ff;
   logic [60:0] absorbed_ff, absorbed_in;
   logic [3:0]  pos_ff;
   logic [5:0]  rnd_ff;
   logic [2:0]  emit_ff;
   // Padding bookkeeping for the message that is being finished.
   logic        pad_active_ff; // a final word was taken, padding is underway
   logic        pad_open_ff;   // opening pad word still to push
   logic        len_hi_ff;     // slot 14 of this block holds the upper length word
   logic        pad_done_ff;   // length words pushed, block is the final one
   logic [63:0] bits;
   logic        push;
   logic [31:0] push_word;
   logic        accept;
   logic        csr_wr;
   sha256_pkg::func_type func;
   logic [2:0]  cnt;

   assign func = sha256_pkg::func_type'(req_tuser);
   assign accept = req_tvalid && req_tready;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {3'b000, offset_ff} : 64'd0;
   assign cnt = (req_tdata[34:32] > 3'd4) ? 3'd4 : req_tdata[34:32];
   assign bits = {offset_ff + absorbed_ff, 3'b000};

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (csr_wr && csr_paddr[2] == 1'b0) begin
         offset_ff <= csr_pwdata[60:0];
      end
   end

   // Next state. Any push into slot 15 fills the block and starts a compression.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha256_pkg::ST_IDLE: begin
            if (accept && func == sha256_pkg::FUNC_ABSORB) begin
               if (pos_ff == 4'd15) begin
                  state_in = sha256_pkg::ST_INIT;
               end else if (req_tlast) begin
                  state_in = sha256_pkg::ST_PAD;
               end
            end
         end
         sha256_pkg::ST_PAD: begin
            if (pos_ff == 4'd15) begin
               state_in = sha256_pkg::ST_INIT;
            end
         end
         sha256_pkg::ST_INIT:  state_in = sha256_pkg::ST_ROUND;
         sha256_pkg::ST_ROUND: begin
            if (rnd_ff == 6'd63) begin
               state_in = sha256_pkg::ST_FOLD;
            end
         end
         sha256_pkg::ST_FOLD: begin
            if (pad_done_ff) begin
               state_in = sha256_pkg::ST_EMIT;
            end else if (pad_active_ff) begin
               state_in = sha256_pkg::ST_PAD;
            end else begin
               state_in = sha256_pkg::ST_IDLE;
            end
         end
         sha256_pkg::ST_EMIT: begin
            if (rsp_tready && emit_ff == 3'd7) begin
               state_in = sha256_pkg::ST_IDLE;
            end
         end
         default: state_in = sha256_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      ctl.init = (state_ff == sha256_pkg::ST_INIT);
      ctl.round = (state_ff == sha256_pkg::ST_ROUND);
      ctl.rnd = rnd_ff;
      req_tready = (state_ff == sha256_pkg::ST_IDLE);
      rsp_tvalid = (state_ff == sha256_pkg::ST_EMIT);
      rsp_tdata = {5'd0, emit_ff, chain_ff[emit_ff]};
      rsp_tlast = (emit_ff == 3'd7);
      push = 1'b0;
      push_word = req_tdata[31:0];
      if (state_ff == sha256_pkg::ST_IDLE && accept &&
          func == sha256_pkg::FUNC_ABSORB) begin
         push = 1'b1;
         if (req_tlast) begin
            unique case (cnt)
               3'd0: push_word = 32'h80000000;
               3'd1: push_word = {req_tdata[31:24], 24'h800000};
               3'd2: push_word = {req_tdata[31:16], 16'h8000};
               3'd3: push_word = {req_tdata[31:8], 8'h80};
               default: push_word = req_tdata[31:0];
            endcase
         end
      end else if (state_ff == sha256_pkg::ST_PAD) begin
         // Once the opening pad word is in, the length takes slots 14 and 15.
         // If the opening word itself lands in slot 14 or 15, the block is
         // closed with zeros and the length goes into the next block.
         push = 1'b1;
         if (pad_open_ff) begin
            push_word = 32'h80000000;
         end else if (pos_ff == 4'd14) begin
            push_word = bits[63:32];
         end else if (pos_ff == 4'd15 && len_hi_ff) begin
            push_word = bits[31:0];
         end else begin
            push_word = 32'd0;
         end
      end
   end

   always_comb begin
      absorbed_in = absorbed_ff;
      if (state_ff == sha256_pkg::ST_IDLE && accept) begin
         if (func == sha256_pkg::FUNC_RESTORE) begin
            absorbed_in = '0;
         end else if (func == sha256_pkg::FUNC_ABSORB) begin
            absorbed_in = absorbed_ff + (req_tlast ? {58'd0, cnt} : 61'd4);
         end
      end else if (state_ff == sha256_pkg::ST_EMIT && rsp_tready && emit_ff == 3'd7) begin
         absorbed_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha256_pkg::ST_IDLE;
         chain_ff <= sha256_pkg::InitH;
         absorbed_ff <= '0;
         pos_ff <= '0;
         rnd_ff <= '0;
         emit_ff <= '0;
         pad_open_ff <= 1'b0;
         pad_done_ff <= 1'b0;
         pad_active_ff <= 1'b0;
         len_hi_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         absorbed_ff <= absorbed_in;
         if (push) begin
            pos_ff <= pos_ff + 4'd1;
         end
         if (state_ff == sha256_pkg::ST_IDLE && accept) begin
            unique case (func)
               sha256_pkg::FUNC_LOAD: chain_ff[req_tdata[37:35]] <= req_tdata[31:0];
               sha256_pkg::FUNC_RESTORE: begin
                  chain_ff <= sha256_pkg::InitH;
                  pos_ff <= '0;
               end
               sha256_pkg::FUNC_ABSORB: begin
                  if (req_tlast) begin
                     pad_active_ff <= 1'b1;
                     pad_open_ff <= (cnt == 3'd4);
                     pad_done_ff <= 1'b0;
                     len_hi_ff <= 1'b0;
                  end
               end
               default: ;
            endcase
         end
         if (state_ff == sha256_pkg::ST_PAD) begin
            pad_open_ff <= 1'b0;
            len_hi_ff <= !pad_open_ff && pos_ff == 4'd14;
            if (!pad_open_ff && pos_ff == 4'd15 && len_hi_ff) begin
               pad_done_ff <= 1'b1;
            end
         end
         if (state_ff == sha256_pkg::ST_ROUND) begin
            rnd_ff <= rnd_ff + 6'd1;
         end
         if (state_ff == sha256_pkg::ST_FOLD) begin
            for (int i = 0; i < 8; i++) begin
               chain_ff[i] <= chain_ff[i] + work[i];
            end
            if (pad_done_ff) begin
               pad_active_ff <= 1'b0;
            end
         end
         if (state_ff == sha256_pkg::ST_EMIT && rsp_tready) begin
            emit_ff <= emit_ff + 3'd1;
            if (emit_ff == 3'd7) begin
               chain_ff <= sha256_pkg::InitH;
               pad_done_ff <= 1'b0;
            end
         end
      end
   end

   sha256_sched u_sched (
      .clock     (clock),
      .push      (push),
      .push_pos  (pos_ff),
      .push_word (push_word),
      .round     (ctl.round),
      .rnd       (rnd_ff),
      .w_word    (w_word)
   );

   sha256_round u_round (
      .clock  (clock),
      .ctl    (ctl),
      .chain  (chain_ff),
      .w_word (w_word),
      .work   (work)
   );

endmodule

// ===== sv/sha256_round.sv =====
module sha256_round (
   input  logic                     clock,
   input  sha256_pkg::rnd_ctl_type  ctl,
   input  logic [31:0]              chain [8],
   input  logic [31:0]              w_word,
   output logic [31:0]              work [8]
);

   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] s1;
   logic [31:0] s0;
   logic [31:0] ch;
   logic [31:0] maj;

   always_comb begin
      s1 = sha256_pkg::rotr(v_ff[4], 6) ^ sha256_pkg::rotr(v_ff[4], 11)
         ^ sha256_pkg::rotr(v_ff[4], 25);
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      s0 = sha256_pkg::rotr(v_ff[0], 2) ^ sha256_pkg::rotr(v_ff[0], 13)
         ^ sha256_pkg::rotr(v_ff[0], 22);
      maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1 = v_ff[7] + s1 + ch + sha256_pkg::RoundK[ctl.rnd] + w_word;
      t2 = s0 + maj;
      v_in = v_ff;
      if (ctl.init) begin
         v_in = chain;
      end else if (ctl.round) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
   end

   assign work = v_ff;

endmodule

// ===== sv/sha256_sched.sv =====
module sha256_sched (
   input  logic        clock,
   input  logic        push,
   input  logic [3:0]  push_pos,
   input  logic [31:0] push_word,
   input  logic        round,
   input  logic [5:0]  rnd,
   output logic [31:0] w_word
);

   logic [31:0] win_ff [16];
   logic [31:0] s0;
   logic [31:0] s1;
   logic [31:0] x15;
   logic [31:0] x2;
   logic [31:0] ext;
   logic [3:0]  slot;

   always_comb begin
      slot = rnd[3:0];
      x15 = win_ff[slot + 4'd1];
      x2 = win_ff[slot + 4'd14];
      s0 = sha256_pkg::rotr(x15, 7) ^ sha256_pkg::rotr(x15, 18) ^ (x15 >> 3);
      s1 = sha256_pkg::rotr(x2, 17) ^ sha256_pkg::rotr(x2, 19) ^ (x2 >> 10);
      ext = win_ff[slot] + s0 + win_ff[slot + 4'd9] + s1;
      w_word = (rnd >= 6'd16) ? ext : win_ff[slot];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         win_ff[push_pos] <= push_word;
      end else if (round) begin
         win_ff[slot] <= w_word;
      end
   end

endmodule

// ===== verif/tb_sha256_hash_engine.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the SHA-256 engine. A directed table covers known
// digests, byte counts, chaining loads and restores; length offsets and random
// messages follow. Every digest item is compared with a model inside the bench.
module tb_sha256_hash_engine;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   sha256_hash_engine dut (.*);

   always #5 clock = ~clock;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_item_type;

   typedef struct {
      sha256_pkg::func_type func;
      logic [31:0] data;
      logic [2:0]  count;
      logic        eom;
      logic [2:0]  sel;
      logic        typed;   // first digest word typed in below
      logic [31:0] first_word;
   } stim_row_type;

   // Local copy of the engine state.
   logic [31:0] chain_h [8];
   logic [31:0] block_w [16];
   logic [3:0]  block_pos;
   logic [60:0] byte_total;
   logic [60:0] len_offset;

   digest_item_type digest_queue [$];
   int          mismatches = 0;
   int unsigned cycle_count = 0;
   bit          calm = 1'b0;   // no idling on either side while set

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Full 64-round compression of block_w into chain_h.
   task automatic compress_model();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int t = 0; t < 64; t++) begin
         if (t < 16) w[t] = block_w[t];
         else w[t] = w[t-16] + w[t-7]
            + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
            + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
      end
      {a, b, c, d, e, f, g, h} = {chain_h[0], chain_h[1], chain_h[2], chain_h[3],
                                  chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
      for (int t = 0; t < 64; t++) begin
         t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
              + sha256_pkg::RoundK[t] + w[t];
         t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
      chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
   endtask

   task automatic append_word(input logic [31:0] w);
      block_w[block_pos] = w;
      block_pos++;
      if (block_pos == 0) compress_model();
   endtask

   task automatic model_init();
      foreach (chain_h[i]) chain_h[i] = sha256_pkg::InitH[i];
      byte_total = '0;
      block_pos = '0;
   endtask

   // Applies one accepted item to the model and queues any digest it produces.
   task automatic predict_sha(input sha256_pkg::func_type func, input logic [31:0] data,
                              input logic [2:0] count_in, input logic eom,
                              input logic [2:0] sel);
      logic [2:0]  count;
      logic [31:0] keep;
      logic [63:0] bit_len;
      digest_item_type item;
      if (func == sha256_pkg::FUNC_LOAD) begin
         chain_h[sel] = data;
      end else if (func == sha256_pkg::FUNC_RESTORE) begin
         model_init();
      end else if (func == sha256_pkg::FUNC_ABSORB) begin
         if (!eom) begin
            byte_total += 61'd4;
            append_word(data);
         end else begin
            count = (count_in > 3'd4) ? 3'd4 : count_in;
            byte_total += 61'(count);
            if (count == 3'd4) begin
               append_word(data);
               append_word(32'h8000_0000);
            end else begin
               keep = (count == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * count));
               append_word((data & keep) | (32'h80 << (24 - 8 * count)));
            end
            while (block_pos != 4'd14) append_word(32'h0);
            bit_len = {3'b000, 61'(len_offset + byte_total)} << 3;
            append_word(bit_len[63:32]);
            append_word(bit_len[31:0]);
            for (int k = 0; k < 8; k++) begin
               item.word = chain_h[k];
               item.index = 3'(k);
               item.last = (k == 7);
               digest_queue.insert(digest_queue.size(), item);
            end
            model_init();
         end
      end
   endtask

   // Sends one item; idles before it at random unless the calm stretch is on.
   task automatic send_item(input sha256_pkg::func_type func, input logic [31:0] data,
                            input logic [2:0] count, input logic eom, input logic [2:0] sel);
      while (!calm && $urandom_range(99) < 22) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {2'b00, sel, count, data};
      req_tlast  <= eom;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_sha(func, data, count, eom, sel);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_offset(input logic [63:0] value);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= 3'd0; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      len_offset = value[60:0];
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Random message: mostly plain words, sometimes loads, restores or noise.
   task automatic send_random_message(input int words);
      int kind;
      for (int i = 0; i < words; i++) begin
         kind = $urandom_range(99);
         if (kind < 4)
            send_item(sha256_pkg::FUNC_LOAD, $urandom, 3'($urandom), 1'($urandom),
                      3'($urandom));
         else if (kind < 6)
            send_item(sha256_pkg::FUNC_UNUSED, $urandom, 3'($urandom), 1'($urandom),
                      3'($urandom));
         else if (kind < 7)
            send_item(sha256_pkg::FUNC_RESTORE, $urandom, 3'($urandom), 1'b0,
                      3'($urandom));
         else
            send_item(sha256_pkg::FUNC_ABSORB, $urandom, 3'($urandom), 1'b0,
                      3'($urandom));
      end
      send_item(sha256_pkg::FUNC_ABSORB, $urandom, 3'($urandom), 1'b1, 3'($urandom));
   endtask

   // Result side: random stalls, compare against the oldest expectation.
   always @(posedge clock) begin
      digest_item_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected digest item %h", rsp_tdata);
         end else begin
            want = digest_queue.pop_front();
            if (rsp_tdata[31:0] !== want.word || rsp_tdata[34:32] !== want.index
                || rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                           want.word, want.index, want.last,
                           rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast);
            end
         end
      end
      rsp_tready <= calm || ($urandom_range(99) >= 22);
   end

   always @(posedge clock) begin
      if (cycle_count > 600000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Directed rows. The digest of the empty message and of "abc" are typed in.
   stim_row_type table_rows [14] = '{
      '{sha256_pkg::FUNC_ABSORB, 32'hffffffff, 3'd0, 1'b1, 3'd0, 1'b1, 32'he3b0c442},
      '{sha256_pkg::FUNC_ABSORB, 32'h61626300, 3'd3, 1'b1, 3'd7, 1'b1, 32'hba7816bf},
      '{sha256_pkg::FUNC_ABSORB, 32'h00000000, 3'd4, 1'b1, 3'd0, 1'b0, 32'h0},
      '{sha256_pkg::FUNC_ABSORB, 32'hffffffff, 3'd7, 1'b1, 3'd0, 1'b0, 32'h0},
      '{sha256_pkg::FUNC_ABSORB, 32'hffffffff, 3'd1, 1'b1, 3'd0, 1'b0, 32'h0},
      '{sha256_pkg::FUNC_ABSORB, 32'hdeadbeef, 3'd2, 1'b1, 3'd0, 1'b0, 32'h0},
      '{sha256_pkg::FUNC_LOAD,   32'hffffffff, 3'd0, 1'b0, 3'd7, 1'b0, 32'h0},
      '{sha256_pkg::FUNC_LOAD,   32'h00000000, 3'd0, 1'b1, 3'd0, 1'b0, 32'h0},
      '{sha256_pkg::FUNC_UNUSED, 32'h12345678, 3'd4, 1'b1, 3'd3, 1'b0, 32'h0},
      '{sha256_pkg::FUNC_ABSORB, 32'h11223344, 3'd5, 1'b0, 3'd0, 1'b0, 32'h0},
      '{sha256_pkg::FUNC_ABSORB, 32'h55667788, 3'd4, 1'b1, 3'd0, 1'b0, 32'h0},
      '{sha256_pkg::FUNC_ABSORB, 32'haaaaaaaa, 3'd0, 1'b0, 3'd0, 1'b0, 32'h0},
      '{sha256_pkg::FUNC_RESTORE, 32'h0,       3'd0, 1'b0, 3'd0, 1'b0, 32'h0},
      '{sha256_pkg::FUNC_ABSORB, 32'h61626300, 3'd3, 1'b1, 3'd0, 1'b1, 32'hba7816bf}
   };

   initial begin
      int n_items;
      int words;
      digest_item_type head;
      model_init();
      len_offset = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[r]) begin
         send_item(table_rows[r].func, table_rows[r].data, table_rows[r].count,
                   table_rows[r].eom, table_rows[r].sel);
         // The digest of this row is the last eight entries of the queue.
         if (table_rows[r].typed && digest_queue.size() >= 8) begin
            head = digest_queue[digest_queue.size() - 8];
            if (head.word !== table_rows[r].first_word) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Known digest row %0d: expected %h, model %h",
                           r, table_rows[r].first_word, head.word);
            end
         end
      end
      // The sender holds here until every digest item has come back.
      drain_results();

      // Length offset extremes, including a bit length that wraps past 2^64.
      write_offset(64'hffff_ffff_ffff_ffff);
      send_item(sha256_pkg::FUNC_ABSORB, 32'h01020304, 3'd4, 1'b1, 3'd0);
      drain_results();
      write_offset(64'h1fff_ffff_ffff_ffc0);
      for (int i = 0; i < 17; i++)
         send_item(sha256_pkg::FUNC_ABSORB, $urandom, 3'd0, 1'b0, 3'd0);
      send_item(sha256_pkg::FUNC_ABSORB, $urandom, 3'd2, 1'b1, 3'd0);
      drain_results();
      write_offset(64'd0);

      // Random part, about 370 items, with a calm stretch in the middle.
      n_items = 0;
      while (n_items < 370) begin
         if (n_items > 150 && n_items < 220) calm = 1'b1;
         else calm = 1'b0;
         if ($urandom_range(99) < 10) begin
            drain_results();
            write_offset({$urandom, $urandom});
         end
         if ($urandom_range(9) == 0) words = $urandom_range(14, 40);
         else words = $urandom_range(0, 15);
         send_random_message(words);
         n_items += words + 1;
      end
      calm = 1'b0;
      drain_results();

      if (mismatches == 0 && digest_queue.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sha256_hash_engine.f =====
sv/sha256_pkg.sv
sv/sha256_round.sv
sv/sha256_sched.sv
sv/sha256_hash_engine.sv
verif/tb_sha256_hash_engine.sv
